>>> rtl/mccf_pkg.sv
`default_nettype none

package mccf_pkg;

   // Charset mode codes; the spare code behaves as UTF-8
   localparam logic [1:0] MODE_EUCKR = 2'd0;
   localparam logic [1:0] MODE_UTF16 = 2'd1;
   localparam logic [1:0] MODE_UTF8  = 2'd2;
   localparam logic [1:0] MODE_RESET = MODE_UTF8;

   // Result status codes
   localparam logic [1:0] STATUS_CHAR     = 2'd0;
   localparam logic [1:0] STATUS_END      = 2'd1;
   localparam logic [1:0] STATUS_BAD_LEAD = 2'd2;

   // Byte classes
   localparam logic [7:0] EUC_LEAD_LOW   = 8'hA1;
   localparam logic [7:0] EUC_LEAD_NONE  = 8'hFF;
   localparam logic [5:0] SURR_HIGH_TAG  = 6'b110110;
   localparam logic [5:0] SURR_LOW_TAG   = 6'b110111;

   // Character assembly state
   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  held;
      logic [2:0]  needed;
   } asm_state_type;

   // One result beat
   typedef struct packed {
      logic [31:0] char_word;
      logic [2:0]  byte_count;
      logic [1:0]  status;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/mccf_decode.sv
`default_nettype none

module mccf_decode (
   input  wire logic [1:0]             mode,
   input  wire mccf_pkg::asm_state_type cur,
   input  wire logic [7:0]             data_byte,
   input  wire logic                   end_of_stream,
   output mccf_pkg::asm_state_type     nxt,
   output logic                        res_valid,
   output mccf_pkg::result_type        res
);
   import mccf_pkg::*;

   logic [31:0] word;
   logic [2:0]  count;
   logic [15:0] unit;

   assign word  = {cur.word[23:0], data_byte};
   assign count = {1'b0, cur.held} + 3'd1;
   assign unit  = {word[7:0], word[15:8]};

   // Classify the byte and advance the assembly
   always_comb begin
      nxt       = cur;
      res_valid = 1'b0;
      res       = '0;
      if (end_of_stream) begin
         // drop any partial character and report end
         nxt        = '0;
         res_valid  = 1'b1;
         res.status = STATUS_END;
      end else if (cur.needed == 3'd0) begin
         unique case (mode)
            MODE_EUCKR: begin
               if (data_byte < EUC_LEAD_LOW || data_byte == EUC_LEAD_NONE) begin
                  res_valid      = 1'b1;
                  res.char_word  = {24'd0, data_byte};
                  res.byte_count = 3'd1;
                  res.status     = STATUS_CHAR;
               end else begin
                  nxt = '{word: {24'd0, data_byte}, held: 2'd1, needed: 3'd2};
               end
            end
            MODE_UTF16: begin
               nxt = '{word: {24'd0, data_byte}, held: 2'd1, needed: 3'd2};
            end
            default: begin
               if (data_byte[7:6] == 2'b10) begin
                  // stray continuation: drop
                  nxt = cur;
               end else if (!data_byte[7]) begin
                  res_valid      = 1'b1;
                  res.char_word  = {24'd0, data_byte};
                  res.byte_count = 3'd1;
                  res.status     = STATUS_CHAR;
               end else if (data_byte[7:5] == 3'b110) begin
                  nxt = '{word: {24'd0, data_byte}, held: 2'd1, needed: 3'd2};
               end else if (data_byte[7:4] == 4'b1110) begin
                  nxt = '{word: {24'd0, data_byte}, held: 2'd1, needed: 3'd3};
               end else if (data_byte[7:3] == 5'b11110) begin
                  nxt = '{word: {24'd0, data_byte}, held: 2'd1, needed: 3'd4};
               end else begin
                  res_valid  = 1'b1;
                  res.status = STATUS_BAD_LEAD;
               end
            end
         endcase
      end else if (count < cur.needed) begin
         // keep gathering
         nxt.word = word;
         nxt.held = count[1:0];
      end else if (mode == MODE_UTF16) begin
         if (cur.needed == 3'd2) begin
            if (unit[15:10] == SURR_HIGH_TAG) begin
               // high surrogate: wait for the low unit
               nxt = '{word: word, held: 2'd2, needed: 3'd4};
            end else begin
               nxt = '0;
               if (unit[15:10] != SURR_LOW_TAG) begin
                  res_valid      = 1'b1;
                  res.char_word  = {16'd0, unit};
                  res.byte_count = 3'd2;
                  res.status     = STATUS_CHAR;
               end
            end
         end else begin
            nxt            = '0;
            res_valid      = 1'b1;
            res.char_word  = {word[23:16], word[31:24], word[7:0], word[15:8]};
            res.byte_count = 3'd4;
            res.status     = STATUS_CHAR;
         end
      end else begin
         nxt            = '0;
         res_valid      = 1'b1;
         res.char_word  = word;
         res.byte_count = cur.needed;
         res.status     = STATUS_CHAR;
      end
   end

endmodule

`default_nettype wire

>>> rtl/multi_charset_char_framer_core.sv
`default_nettype none
// Channel | Direction | Beat carries                          | Handshake
// req     | in        | data_byte, end_of_stream              | req_valid / req_ready
// rsp     | out       | char_word, byte_count, status         | rsp_valid / rsp_ready
// csr     | in        | charset_mode                          | csr_valid / csr_ready
//
// One byte is taken per cycle while req_ready is high; its result, if any, is
// registered. Classification and assembly sit in one short step between the
// byte and the result register; a two-entry output buffer (result register
// plus skid) keeps req_ready high while a result waits. req_ready falls only
// when both are full. Reset selects UTF-8 and clears the assembly; csr_ready
// is always high and a mode write discards any character in progress.
module multi_charset_char_framer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_stream,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_char_word,
   output logic [2:0]       rsp_byte_count,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_charset_mode
);
   import mccf_pkg::*;

   logic [1:0]    mode_ff;
   asm_state_type state_ff, state_in;
   logic          dec_valid;
   result_type    dec_res;
   logic          out_valid_ff, skid_valid_ff;
   result_type    out_ff, skid_ff;
   logic          req_beat, csr_beat, out_take, push;

   assign csr_ready = 1'b1;
   assign req_ready = !skid_valid_ff;
   assign req_beat  = req_valid && req_ready;
   assign csr_beat  = csr_valid && csr_ready;
   assign out_take  = out_valid_ff && rsp_ready;
   assign push      = req_beat && dec_valid;

   mccf_decode u_decode (
      .mode          (mode_ff),
      .cur           (state_ff),
      .data_byte     (req_data_byte),
      .end_of_stream (req_end_of_stream),
      .nxt           (state_in),
      .res_valid     (dec_valid),
      .res           (dec_res)
   );

   // Hold mode and assembly state; a mode write clears the assembly
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_RESET;
         state_ff <= '0;
      end else if (csr_beat) begin
         mode_ff  <= csr_charset_mode;
         state_ff <= '0;
      end else if (req_beat) begin
         state_ff <= state_in;
      end
   end

   // Advance the two-entry output buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         if (out_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end
   end

   // Load result payloads
   always_ff @(posedge clock) begin
      if (out_take) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (push) begin
            out_ff <= dec_res;
         end
      end else if (push) begin
         if (out_valid_ff) begin
            skid_ff <= dec_res;
         end else begin
            out_ff <= dec_res;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_char_word  = out_ff.char_word;
   assign rsp_byte_count = out_ff.byte_count;
   assign rsp_status     = out_ff.status;

`ifndef NO_ASSERTIONS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a result in front");

   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      csr_beat |=> (state_ff.held == 2'd0 && state_ff.needed == 3'd0))
      else $error("mode write left a character in progress");

   a_state_shape: assert property (@(posedge clock) disable iff (reset)
      (state_ff.needed == 3'd0) ? (state_ff.held == 2'd0)
                                : ({1'b0, state_ff.held} < state_ff.needed
                                   && state_ff.needed != 3'd1))
      else $error("assembly count out of shape");

   a_end_reported: assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_end_of_stream && !csr_beat) |=>
         (out_valid_ff && state_ff.needed == 3'd0))
      else $error("end of stream not reported");
`endif

endmodule

`default_nettype wire
